// ===== design/u8wd_pkg.sv =====
// ----------------------------------------------------------------------------
// u8wd_pkg
// Shared types and constants for the UTF-8 window decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8wd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CP_W    = 21;
	localparam int unsigned LEN_W   = 3;
	localparam int unsigned LANES   = 4;

	localparam logic [CP_W-1:0]  REPL_CHAR = 21'h00FFFD;

	localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
	localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
	localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
	localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

	// per-byte classification found by one lane
	typedef struct packed {
		logic       is_ascii;  // 0x00-0x7F
		logic       is_cont;   // 0x80-0xBF
		logic       is_lead2;  // 0xC0-0xDF
		logic       is_lead3;  // 0xE0-0xEF
		logic       is_lead4;  // 0xF0-0xF7
		logic [6:0] low;       // low seven bits of the byte
	} lane_t;

	// merged decode result
	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic [LEN_W-1:0] length;
		logic             malformed;
	} result_t;

endpackage

`default_nettype wire

// ===== design/utf8_window_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_window_decoder
// Stateless UTF-8 decoder over a four-byte window starting at a lead byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one window per beat: lead_byte,
//   second_byte, third_byte, fourth_byte. Output channel out_valid/out_ready
//   carries one result per window: code_point, consumed_length, malformed.
//   Four byte lanes classify the window in parallel; their results are
//   registered in stage 1, then a merge stage builds the result, which is
//   held in the stage 2 output register.
//   Throughput: one window per cycle while the receiver takes results.
//   When out_ready is low the output register holds its result; stage 1
//   still takes one more window if empty, then in_ready drops until the
//   output drains. No window is lost or repeated.
//   Reset (arst_n low) empties both stages; nothing else is kept.
//   The caller advances its byte pointer by consumed_length.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_window_decoder (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [u8wd_pkg::BYTE_W-1:0]     lead_byte,
	input  wire logic [u8wd_pkg::BYTE_W-1:0]     second_byte,
	input  wire logic [u8wd_pkg::BYTE_W-1:0]     third_byte,
	input  wire logic [u8wd_pkg::BYTE_W-1:0]     fourth_byte,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [u8wd_pkg::CP_W-1:0]            code_point,
	output logic [u8wd_pkg::LEN_W-1:0]           consumed_length,
	output logic                                 malformed
);

	u8wd_pkg::lane_t   lane_info [u8wd_pkg::LANES];
	u8wd_pkg::lane_t   lane_s1   [u8wd_pkg::LANES];
	logic              valid_s1;
	u8wd_pkg::result_t merged;
	u8wd_pkg::result_t result_s2;
	logic              valid_s2;
	logic              adv_s1;
	logic              adv_s2;

	// byte lanes
	u8wd_lane u_lane0 (.byte_in(lead_byte),   .info(lane_info[0]));
	u8wd_lane u_lane1 (.byte_in(second_byte), .info(lane_info[1]));
	u8wd_lane u_lane2 (.byte_in(third_byte),  .info(lane_info[2]));
	u8wd_lane u_lane3 (.byte_in(fourth_byte), .info(lane_info[3]));

	// stage advance control
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// stage 1 lane payload
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			lane_s1 <= lane_info;
		end
	end

	// merge of lane results
	u8wd_merge u_merge (
		.lane0  (lane_s1[0]),
		.lane1  (lane_s1[1]),
		.lane2  (lane_s1[2]),
		.lane3  (lane_s1[3]),
		.result (merged)
	);

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// stage 2 result payload
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= merged;
		end
	end

	// output beat
	assign out_valid       = valid_s2;
	assign code_point      = result_s2.code_point;
	assign consumed_length = result_s2.length;
	assign malformed       = result_s2.malformed;

endmodule

`default_nettype wire

// ===== design/u8wd_lane.sv =====
// ----------------------------------------------------------------------------
// u8wd_lane
// Classifies one byte of the window and keeps its payload bits.
// ----------------------------------------------------------------------------
`default_nettype none

module u8wd_lane (
	input  wire logic [u8wd_pkg::BYTE_W-1:0] byte_in,
	output u8wd_pkg::lane_t                  info
);

	// range checks on the top bits
	always_comb begin
		info.is_ascii = (byte_in[7] == 1'b0);
		info.is_cont  = (byte_in[7:6] == 2'b10);
		info.is_lead2 = (byte_in[7:5] == 3'b110);
		info.is_lead3 = (byte_in[7:4] == 4'b1110);
		info.is_lead4 = (byte_in[7:3] == 5'b11110);
		info.low      = byte_in[6:0];
	end

endmodule

`default_nettype wire

// ===== design/u8wd_merge.sv =====
// ----------------------------------------------------------------------------
// u8wd_merge
// Combines the four lane classifications into code point, length and flag.
// ----------------------------------------------------------------------------
`default_nettype none

module u8wd_merge (
	input  wire u8wd_pkg::lane_t lane0,
	input  wire u8wd_pkg::lane_t lane1,
	input  wire u8wd_pkg::lane_t lane2,
	input  wire u8wd_pkg::lane_t lane3,
	output u8wd_pkg::result_t    result
);

	logic ok2;
	logic ok3;
	logic ok4;

	// continuation checks per sequence length
	assign ok2 = lane1.is_cont;
	assign ok3 = lane1.is_cont & lane2.is_cont;
	assign ok4 = lane1.is_cont & lane2.is_cont & lane3.is_cont;

	// select by lead class, replacement by default
	always_comb begin
		result.code_point = u8wd_pkg::REPL_CHAR;
		result.length     = u8wd_pkg::LEN_ONE;
		result.malformed  = 1'b1;
		if (lane0.is_ascii) begin
			result.code_point = {14'd0, lane0.low};
			result.malformed  = 1'b0;
		end else if (lane0.is_lead2) begin
			if (ok2) begin
				result.code_point = {10'd0, lane0.low[4:0], lane1.low[5:0]};
				result.length     = u8wd_pkg::LEN_TWO;
				result.malformed  = 1'b0;
			end
		end else if (lane0.is_lead3) begin
			if (ok3) begin
				result.code_point = {5'd0, lane0.low[3:0], lane1.low[5:0],
					lane2.low[5:0]};
				result.length     = u8wd_pkg::LEN_THREE;
				result.malformed  = 1'b0;
			end
		end else if (lane0.is_lead4) begin
			result.length = u8wd_pkg::LEN_FOUR;
			if (ok4) begin
				result.code_point = {lane0.low[2:0], lane1.low[5:0],
					lane2.low[5:0], lane3.low[5:0]};
				result.malformed  = 1'b0;
			end
		end
	end

endmodule

`default_nettype wire
